// ----- hdl/bmt_pkg.sv -----
// package for the breakpoint match table: sizes, codes, word types and helpers
`default_nettype none

package bmt_pkg;

  localparam int MAX_BREAKPOINTS = 16;
  localparam int HIT_COUNT_WIDTH = 16;

  localparam int IdxW    = (MAX_BREAKPOINTS > 1) ? $clog2(MAX_BREAKPOINTS) : 1;
  localparam int CmpW    = (IdxW > 4) ? IdxW : 4;
  localparam int HitExtW = (HIT_COUNT_WIDTH > 16) ? HIT_COUNT_WIDTH : 16;

  localparam logic [2:0] KIND_LIMIT = 3'd4;
  localparam logic [4:0] COUNT_MAX  = 5'd31;

  typedef enum logic [1:0] {
    REQ_CHECK = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  access_kind;
    logic [19:0] access_address;
    logic [3:0]  entry_select;
  } bmt_req_t;

  typedef struct packed {
    logic        halt_request;
    logic [4:0]  match_count;
    logic        table_full;
    logic        read_valid;
    logic [2:0]  read_kind;
    logic [19:0] read_address;
    logic [15:0] read_hits;
  } bmt_rsp_t;

  // word handed from cell to cell
  typedef struct packed {
    logic        valid;
    req_e        req;
    logic [2:0]  kind;
    logic [19:0] addr;
    logic [3:0]  sel;
    logic [4:0]  count;
    logic        placed;
    logic        rd_valid;
    logic [2:0]  rd_kind;
    logic [19:0] rd_addr;
    logic [15:0] rd_hits;
  } bmt_word_t;

  function automatic logic [15:0] hits_to_read(input logic [HIT_COUNT_WIDTH-1:0] h);
    logic [HitExtW-1:0] ext;
    ext = HitExtW'(h);
    return ext[15:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/bmt_cell.sv -----
// one breakpoint slot of the table, with its stage of the request pipeline
`default_nettype none

module bmt_cell (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [bmt_pkg::IdxW-1:0] cell_idx_i,
  input  wire bmt_pkg::bmt_word_t      word_i,
  output      bmt_pkg::bmt_word_t      word_o
);
  import bmt_pkg::*;

  logic                       valid_q, valid_d;
  logic [2:0]                 kind_q, kind_d;
  logic [19:0]                addr_q, addr_d;
  logic [HIT_COUNT_WIDTH-1:0] hits_q, hits_d;
  bmt_word_t                  word_q, word_d;

  logic hit;
  logic take;
  logic sel_hit;

  assign hit     = word_i.valid && (word_i.req == REQ_CHECK) && valid_q &&
                   (kind_q == word_i.kind) && (addr_q == word_i.addr);
  assign take    = word_i.valid && (word_i.req == REQ_ADD) && (word_i.kind <= KIND_LIMIT) &&
                   !word_i.placed && !valid_q;
  assign sel_hit = word_i.valid && (word_i.req == REQ_READ) && valid_q &&
                   (CmpW'(word_i.sel) == CmpW'(cell_idx_i));

  always_comb begin
    valid_d = valid_q;
    kind_d  = kind_q;
    addr_d  = addr_q;
    hits_d  = hits_q;
    word_d  = word_i;
    if (hit) begin
      if (hits_q != '1) begin
        hits_d = hits_q + HIT_COUNT_WIDTH'(1);
      end
      if (word_i.count != COUNT_MAX) begin
        word_d.count = word_i.count + 5'd1;
      end
    end
    if (take) begin
      valid_d       = 1'b1;
      kind_d        = word_i.kind;
      addr_d        = word_i.addr;
      hits_d        = '0;
      word_d.placed = 1'b1;
    end
    if (word_i.valid && (word_i.req == REQ_CLEAR)) begin
      valid_d = 1'b0;
      hits_d  = '0;
    end
    if (sel_hit) begin
      word_d.rd_valid = 1'b1;
      word_d.rd_kind  = kind_q;
      word_d.rd_addr  = addr_q;
      word_d.rd_hits  = hits_to_read(hits_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      word_q  <= '0;
    end else begin
      valid_q <= valid_d;
      word_q  <= word_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    addr_q <= addr_d;
    hits_q <= hits_d;
  end

  assign word_o = word_q;

endmodule

`default_nettype wire

// ----- hdl/breakpoint_match_table.sv -----
// top level of the breakpoint match table: cell chain and result formatting
`default_nettype none

// Breakpoint match table. A request word (access check, add breakpoint, clear
// all, read entry) is taken at every rising edge where start_i is high and
// busy_o is low; busy_o is never raised, so one request per cycle is taken.
// Each request walks a chain of MAX_BREAKPOINTS cells, one cell per cycle, and
// each cell holds one breakpoint slot: it compares and bumps its hit counter,
// claims an add if it is the first free slot, clears itself, or puts its
// contents on the word for a read. Because every cell sees the requests in
// order, a new request may follow directly behind the previous one. The result
// word appears on rsp_o with done_o high for exactly one cycle, once its
// request has passed through the register of every cell in the chain. The
// receiver cannot stall: results must be taken in the cycle they appear.
// Fields that do not belong to the request read zero.
module breakpoint_match_table (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output      logic              busy_o,
  input  wire bmt_pkg::bmt_req_t req_i,
  output      logic              done_o,
  output      bmt_pkg::bmt_rsp_t rsp_o
);
  import bmt_pkg::*;

  // chain_w[i] enters cell i, chain_w[i+1] leaves it
  bmt_word_t chain_w [MAX_BREAKPOINTS+1];
  bmt_word_t last_w;

  // the pipeline never backs up, so requests are always taken
  assign busy_o = 1'b0;

  // fresh word for the head of the chain
  always_comb begin
    chain_w[0]          = '0;
    chain_w[0].valid    = start_i;
    chain_w[0].req      = req_e'(req_i.req_type);
    chain_w[0].kind     = req_i.access_kind;
    chain_w[0].addr     = req_i.access_address;
    chain_w[0].sel      = req_i.entry_select;
  end

  for (genvar i = 0; i < MAX_BREAKPOINTS; i++) begin : g_cell
    bmt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IdxW'(i)),
      .word_i     (chain_w[i]),
      .word_o     (chain_w[i+1])
    );
  end

  assign last_w = chain_w[MAX_BREAKPOINTS];

  // last cell output is registered, so results come straight off it
  assign done_o = last_w.valid;

  always_comb begin
    rsp_o              = '0;
    rsp_o.match_count  = last_w.count;
    rsp_o.halt_request = (last_w.req == REQ_CHECK) && (last_w.count != 5'd0);
    // an add with a legal kind that no free slot claimed
    rsp_o.table_full   = (last_w.req == REQ_ADD) && (last_w.kind <= KIND_LIMIT) &&
                         !last_w.placed;
    rsp_o.read_valid   = last_w.rd_valid;
    rsp_o.read_kind    = last_w.rd_kind;
    rsp_o.read_address = last_w.rd_addr;
    rsp_o.read_hits    = last_w.rd_hits;
  end

`ifndef ASSERT_OFF
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(MAX_BREAKPOINTS) done_o)
    else $error("result missing after chain latency");

  a_latency_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, MAX_BREAKPOINTS))
    else $error("result without matching request");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($countones({rsp_o.halt_request, rsp_o.table_full, rsp_o.read_valid}) <= 1))
    else $error("result mixes fields of different requests");
`endif

endmodule

`default_nettype wire
